>>> src/swq_pkg.sv
// Shared constants and types for the sleep/wake timer queue.
// Depends on nothing; imported by the top level.
`default_nettype none

package swq_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int YIELD_PERIOD_DEF = 5;
  localparam int MAX_WAKE         = 16;
  localparam int WAKE_CNT_W       = $clog2(MAX_WAKE + 1);
  localparam int TIME_W           = 64;
  localparam int ID_W             = 8;
  localparam int KIND_W           = 2;
  localparam int YC_W             = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_WOKEN      = 2'd0,
    KIND_TICK_DONE  = 2'd1,
    KIND_SLEEP_OK   = 2'd2,
    KIND_QUEUE_FULL = 2'd3
  } kind_t;

  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

endpackage

`default_nettype wire

>>> src/swq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/sleep_wake_queue.sv
// Sleep/wake timer queue: top level, sequencer and tick counter.
// Depends on swq_pkg and swq_ram.
//
// Usage:
//   Input channel: present cmd, proc_id and duration with start high; the beat
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: each result is marked by strobe, high for exactly one cycle,
//   on kind, woken_id, yield_now and last. The receiver cannot hold it off.
//   Sleep request: wake time = tick count + duration (mod 2^64). An insertion
//   sort walks the table from its tail, moving one later entry up per cycle
//   through the single RAM port pair, and drops the new entry into the hole.
//   busy stays high while later entries are moved and the new entry is written;
//   the accepted answer strobes in the first cycle with busy low.
//   Queue full: answered in the cycle after the beat, busy never rises.
//   Tick: advance the tick count, then emit one woken result per cycle from
//   the head of the table (at most MAX_WAKE), then tick done with last set.
//   busy stays high through the wake walk; the RAM read of the next head entry
//   is issued in the cycle before its compare, which sets this one-per-cycle rate.
//   Entries live in a circular RAM; waking advances the head pointer and lowers
//   the fill count, and no entry moves. Reset (rst, synchronous): clear tick count,
//   table fill and head pointer. The RAM is not cleared; only entries below the fill count are ever used.
`default_nettype none

module sleep_wake_queue import swq_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int YIELD_PERIOD = YIELD_PERIOD_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd,
  input  wire logic [ID_W-1:0]   proc_id,
  input  wire logic [TIME_W-1:0] duration,
  output logic                   strobe,
  output logic [KIND_W-1:0]      kind,
  output logic [ID_W-1:0]        woken_id,
  output logic                   yield_now,
  output logic                   last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int DEPTH = 1 << IDX_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = TIME_W + ID_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_WAKE
  } state_t;

  state_t                state;
  logic [TIME_W-1:0]     tick_count;
  logic [YC_W-1:0]       ycnt;       // tick_count modulo YIELD_PERIOD
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;        // hole position during insertion
  logic [TIME_W-1:0]     wt;
  logic [ID_W-1:0]       new_id;
  logic [WAKE_CNT_W-1:0] nwoken;

  logic                  accept;
  logic                  we;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENT_W-1:0]      rd_data;
  logic [TIME_W-1:0]     rd_wake;
  logic [ID_W-1:0]       rd_id;
  logic                  shift_more;
  logic                  wake_hit;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign rd_wake    = rd_data[ENT_W-1:ID_W];
  assign rd_id      = rd_data[ID_W-1:0];
  // Later entry strictly after the new wake time: move it up one slot.
  assign shift_more = (rd_wake > wt);
  assign wake_hit   = (count != '0) && (nwoken < WAKE_CNT_W'(MAX_WAKE)) &&
                      (rd_wake <= tick_count);

  // RAM address and write steering.
  always_comb begin
    rd_addr = head;
    we      = 1'b0;
    wr_addr = head + idx[IDX_W-1:0];
    wr_data = {wt, new_id};
    unique case (state)
      ST_IDLE: begin
        // Prefetch the tail for a sleep, the head for a tick.
        if (cmd == CMD_SLEEP) begin
          rd_addr = head + count[IDX_W-1:0] - IDX_W'(1);
        end
      end
      ST_INS_SHIFT: begin
        we = 1'b1;
        if (shift_more) begin
          wr_data = rd_data;
          rd_addr = head + idx[IDX_W-1:0] - IDX_W'(2);
        end
      end
      ST_INS_PUT: begin
        we = 1'b1;
      end
      ST_WAKE: begin
        rd_addr = wake_hit ? head + IDX_W'(1) : head;
      end
    endcase
  end

  swq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      ycnt       <= '0;
      head       <= '0;
      count      <= '0;
      idx        <= '0;
      nwoken     <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_TICK) begin
              tick_count <= tick_count + TIME_W'(1);
              // Step the modulo counter, wrapping at YIELD_PERIOD, and re-sync it when the tick count wraps to zero.
              if (tick_count == {TIME_W{1'b1}} ||
                  ycnt == YC_W'(YIELD_PERIOD - 1)) begin
                ycnt <= '0;
              end else begin
                ycnt <= ycnt + YC_W'(1);
              end
              nwoken <= '0;
              state  <= ST_WAKE;
            end else if (count >= CNT_W'(CAPACITY)) begin
              strobe    <= 1'b1;
              kind      <= KIND_QUEUE_FULL;
              woken_id  <= proc_id;
              yield_now <= 1'b0;
              last      <= 1'b1;
            end else begin
              wt     <= tick_count + duration;
              new_id <= proc_id;
              idx    <= count;
              state  <= (count == '0) ? ST_INS_PUT : ST_INS_SHIFT;
            end
          end
        end
        ST_INS_SHIFT: begin
          if (shift_more) begin
            idx <= idx - CNT_W'(1);
            if (idx == CNT_W'(1)) begin
              state <= ST_INS_PUT;
            end
          end else begin
            count     <= count + CNT_W'(1);
            strobe    <= 1'b1;
            kind      <= KIND_SLEEP_OK;
            woken_id  <= new_id;
            yield_now <= 1'b0;
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_INS_PUT: begin
          count     <= count + CNT_W'(1);
          strobe    <= 1'b1;
          kind      <= KIND_SLEEP_OK;
          woken_id  <= new_id;
          yield_now <= 1'b0;
          last      <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_WAKE: begin
          strobe <= 1'b1;
          if (wake_hit) begin
            kind      <= KIND_WOKEN;
            woken_id  <= rd_id;
            yield_now <= 1'b0;
            last      <= 1'b0;
            head      <= head + IDX_W'(1);
            count     <= count - CNT_W'(1);
            nwoken    <= nwoken + WAKE_CNT_W'(1);
          end else begin
            kind      <= KIND_TICK_DONE;
            woken_id  <= '0;
            yield_now <= (ycnt == '0);
            last      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The closing result of an item coincides with the sequencer being free.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("last result while still busy");

  // Only woken results come without last.
  a_mid_woken: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> kind == KIND_WOKEN)
    else $error("non-final result of wrong kind");

  // Every accepted beat either starts work or answers at once.
  a_accept_acts: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || strobe)
    else $error("accepted beat dropped");

endmodule

`default_nettype wire

>>> dv/tb_sleep_wake_queue.sv
// Self-checking testbench for sleep_wake_queue: a directed table of sleep and tick
// commands, then ~500 random beats, checked against an in-bench predictor.
// Depends on swq_pkg and the sleep_wake_queue RTL.
module tb_sleep_wake_queue import swq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int YIELD_PERIOD = YIELD_PERIOD_DEF;
  localparam int RANDOM_BEATS = 500;
  localparam int CALM_TAIL    = 100;   // last beats of the run go out back to back
  localparam int QUIET_LIMIT  = 2000;  // cycles with neither a beat nor a result
  localparam int SETTLE       = 40;    // well past the longest tick walk

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] id;
    logic            yld;
    logic            last;
  } wake_result_t;

  // One row of the directed plan; reps > 1 repeats it with the id counting up.
  // Rows with pinned set carry a final result read straight off the spec.
  typedef struct {
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dur;
    int                reps;
    logic              pinned;
    kind_t             pin_kind;
    logic              pin_yld;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              cmd;
  logic [ID_W-1:0]   proc_id;
  logic [TIME_W-1:0] duration;
  logic              strobe;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   woken_id;
  logic              yield_now;
  logic              last;

  sleep_wake_queue #(
    .CAPACITY     (CAPACITY),
    .YIELD_PERIOD (YIELD_PERIOD)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .proc_id   (proc_id),
    .duration  (duration),
    .strobe    (strobe),
    .kind      (kind),
    .woken_id  (woken_id),
    .yield_now (yield_now),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state: its own tick counter and sorted sleeper table.
  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] wake_at [CAPACITY];
  logic [ID_W-1:0]   sleeper [CAPACITY];
  int                held;

  wake_result_t      due_results [$];
  plan_row_t         plan [$];
  int                mismatches;
  int                quiet_cycles;

  // Work out the results of one accepted beat and advance the predicted table.
  task automatic compute_wakeups(input logic c, input logic [ID_W-1:0] id,
                                 input logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] wt;
    int                pos;
    int                n;
    int                i;
    if (c == CMD_SLEEP) begin
      if (held >= CAPACITY) begin
        // Full table: answer and change nothing.
        due_results.push_back('{KIND_QUEUE_FULL, id, 1'b0, 1'b1});
      end else begin
        wt  = now_ticks + dur;  // wraps mod 2^64, compared as plain unsigned
        pos = 0;
        // Land after every entry that is due no later, so ties keep arrival order.
        while (pos < held && wake_at[pos] <= wt) pos++;
        for (i = held; i > pos; i--) begin
          wake_at[i] = wake_at[i-1];
          sleeper[i] = sleeper[i-1];
        end
        wake_at[pos] = wt;
        sleeper[pos] = id;
        held++;
        due_results.push_back('{KIND_SLEEP_OK, id, 1'b0, 1'b1});
      end
    end else begin
      now_ticks++;
      n = 0;
      // Pop due sleepers off the head, capped per tick; the rest wait for later ticks.
      while (n < held && n < MAX_WAKE && wake_at[n] <= now_ticks) begin
        due_results.push_back('{KIND_WOKEN, sleeper[n], 1'b0, 1'b0});
        n++;
      end
      for (i = n; i < held; i++) begin
        wake_at[i-n] = wake_at[i];
        sleeper[i-n] = sleeper[i];
      end
      held -= n;
      due_results.push_back('{KIND_TICK_DONE, {ID_W{1'b0}},
                              (now_ticks % YIELD_PERIOD) == 0, 1'b1});
    end
  endtask

  // Present one beat, hold it until busy is low at an edge, then predict.
  task automatic issue(input logic c, input logic [ID_W-1:0] id,
                       input logic [TIME_W-1:0] dur);
    start    <= 1'b1;
    cmd      <= c;
    proc_id  <= id;
    duration <= dur;
    do @(posedge clk); while (busy);
    compute_wakeups(c, id, dur);
  endtask

  // Drop start for a gap of length n; with drain set, also hold until the table has
  // answered everything owed so far. n must be at least 1.
  task automatic hold_off(input int n, input bit drain);
    start <= 1'b0;
    repeat (n) @(posedge clk);
    if (drain) begin
      while (due_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic c, input logic [ID_W-1:0] id,
                         input logic [TIME_W-1:0] dur, input int reps,
                         input logic pinned, input kind_t pk, input logic py);
    plan.push_back('{c, id, dur, reps, pinned, pk, py});
  endtask

  // Result side: the receiver cannot stall, so every strobe is a beat.
  always @(posedge clk) begin
    wake_result_t want;
    wake_result_t seen;
    if (!rst && strobe) begin
      seen = '{kind_t'(kind), woken_id, yield_now, last};
      if (due_results.size() == 0) begin
        $display("%0t ns: unexpected result: kind=%0d id=%0d yield=%0d last=%0d",
                 $time, kind, woken_id, yield_now, last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (seen !== want) begin
          $display("%0t ns: mismatch: expected kind=%0d id=%0d yield=%0d last=%0d, ",
                   $time, want.kind, want.id, want.yld, want.last,
                   "actual kind=%0d id=%0d yield=%0d last=%0d",
                   kind, woken_id, yield_now, last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles where neither side moves a beat.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb_sleep_wake_queue: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int               sleep_pct;
    int               gap_pct;
    int               sel;
    logic             c;
    logic [TIME_W-1:0] dur;
    plan_row_t        row;

    mismatches   = 0;
    quiet_cycles = 0;
    now_ticks    = '0;
    held         = 0;
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= CMD_SLEEP;
    proc_id  <= '0;
    duration <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. Tick count comments give the value after the row.
    add_row(CMD_TICK,  8'h00, 64'd0, 1, 1'b1, KIND_TICK_DONE, 1'b0);    // count 1, empty
    add_row(CMD_SLEEP, 8'h00, 64'd0, 1, 1'b1, KIND_SLEEP_OK, 1'b0);     // zero sleep, wake 1
    add_row(CMD_SLEEP, 8'hFF, '1,    1, 1'b1, KIND_SLEEP_OK, 1'b0);     // wraps to wake 0
    add_row(CMD_SLEEP, 8'h55, 64'd1, 1, 1'b0, KIND_WOKEN, 1'b0);        // wake 2
    add_row(CMD_SLEEP, 8'hAA, 64'd1, 1, 1'b0, KIND_WOKEN, 1'b0);        // tie, stays behind 55
    add_row(CMD_SLEEP, 8'h10, 64'd1, 12, 1'b0, KIND_WOKEN, 1'b0);       // fill the table
    add_row(CMD_SLEEP, 8'h77, 64'd0, 1, 1'b1, KIND_QUEUE_FULL, 1'b0);   // refused when full
    add_row(CMD_TICK,  8'h00, 64'd0, 1, 1'b0, KIND_WOKEN, 1'b0);        // count 2, all 16 wake
    add_row(CMD_TICK,  8'h00, 64'd0, 2, 1'b0, KIND_WOKEN, 1'b0);        // counts 3 and 4
    add_row(CMD_TICK,  8'h00, 64'd0, 1, 1'b1, KIND_TICK_DONE, 1'b1);    // count 5 yields
    add_row(CMD_SLEEP, 8'h33, 64'h8000_0000_0000_0000, 1, 1'b0, KIND_WOKEN, 1'b0);
    add_row(CMD_SLEEP, 8'hCC, 64'd0, 1, 1'b0, KIND_WOKEN, 1'b0);        // due at current count
    add_row(CMD_TICK,  8'h00, 64'd0, 1, 1'b0, KIND_WOKEN, 1'b0);        // count 6 wakes CC

    foreach (plan[k]) begin
      row = plan[k];
      for (int r = 0; r < row.reps; r++) begin
        issue(row.cmd, ID_W'(row.id + r), row.dur);
        // Overwrite the closing expectation with the value pinned in the table.
        if (row.pinned) begin
          due_results[due_results.size()-1] =
            '{row.pin_kind, (row.cmd == CMD_TICK) ? {ID_W{1'b0}} : ID_W'(row.id + r),
              row.pin_yld, 1'b1};
        end
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 13), 1'b0);
      end
    end

    // Let the directed part drain completely before the random traffic.
    hold_off(1, 1'b1);

    sleep_pct = 50;
    gap_pct   = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // Re-pick the mix every 50 beats: tick-heavy, balanced or fill-heavy,
      // with no gaps, occasional gaps or frequent gaps.
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: sleep_pct = 15;
          1: sleep_pct = 50;
          default: sleep_pct = 85;
        endcase
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 25;
          default: gap_pct = 60;
        endcase
      end

      c = ($urandom_range(0, 99) < sleep_pct) ? CMD_SLEEP : CMD_TICK;
      // Mostly short sleeps so entries keep waking; a few wrap or never wake.
      sel = $urandom_range(0, 49);
      if (sel < 28)      dur = TIME_W'($urandom_range(0, 6));
      else if (sel < 40) dur = TIME_W'($urandom_range(0, 60));
      else if (sel < 46) dur = ~TIME_W'(0) - TIME_W'($urandom_range(0, 8));
      else if (sel < 49) dur = $urandom_range(0, 1) ? '1 : '0;
      else               dur = {$urandom, $urandom};

      issue(c, ID_W'($urandom_range(0, 255)), dur);

      if (i % 150 == 75) begin
        hold_off(1, 1'b1);
      end else if (i < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
        hold_off($urandom_range(1, 13), 1'b0);
      end
    end
    start <= 1'b0;

    // Drain what is owed, then watch a while longer for stray results.
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_sleep_wake_queue: PASS");
    end else begin
      $display("tb_sleep_wake_queue: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/swq_pkg.sv
src/swq_ram.sv
src/sleep_wake_queue.sv
dv/tb_sleep_wake_queue.sv
